### rtl/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared types and constants for the keyed count table.
// ----------------------------------------------------------------------------
package kct_pkg;

	localparam int KEY_W    = 64;
	localparam int CNT_W    = 32;
	localparam int AMT_W    = 16;
	localparam int OP_W     = 2;
	localparam int POS_W    = 6;
	localparam int USED_W   = 7;

	localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} entry_t;

endpackage

### rtl/keyed_count_table_top.sv
// ----------------------------------------------------------------------------
// keyed_count_table_top
// Ordered table of 64-bit keys with saturating 32-bit counts. Each
// transaction searches the table in order, then queries, adds or removes.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// command   in         start, busy           operation, item_key, amount
// result    out        done (no back-press)  found, position, count_after,
//                                            entries_used, table_full
//
// All entries sit in one single-port-read / single-port-write memory.
// Search streams one entry per cycle and stops at the first hit or after the
// last used entry. A delete then shifts the later entries down at one entry
// per cycle. done rises in the first cycle that busy is low. Reset empties
// the table at once.
// ----------------------------------------------------------------------------
module keyed_count_table_top
	import kct_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   operation,
	input  logic [KEY_W-1:0]  item_key,
	input  logic [AMT_W-1:0]  amount,
	output logic              done,
	output logic              found,
	output logic [POS_W-1:0]  position,
	output logic [CNT_W-1:0]  count_after,
	output logic [USED_W-1:0] entries_used,
	output logic              table_full
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT
	} state_t;

	state_t            state_q;
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [AMT_W-1:0]  amt_q;
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     rd_ptr_q;
	logic              rd_vld_s1;
	logic [AW-1:0]     rd_addr_s1;

	entry_t            mem [CAPACITY];
	entry_t            mem_rdata_s1;

	logic              rd_en;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;

	logic              hit;
	logic              last;
	logic              miss;
	logic              has_room;
	logic              shift_end;
	logic [CNT_W:0]    sum;
	logic [CNT_W-1:0]  sat_cnt;
	logic [CNT_W-1:0]  amt_ext;
	logic              del;

	assign busy     = (state_q != ST_IDLE);
	assign amt_ext  = CNT_W'(amt_q);
	assign has_room = (used_q < CW'(CAPACITY));
	assign last     = rd_vld_s1 && (CW'(rd_addr_s1) == used_q - CW'(1));
	assign hit      = (state_q == ST_SEARCH) && rd_vld_s1 && (mem_rdata_s1.key == key_q);
	assign miss     = (state_q == ST_SEARCH) && !hit && (last || (used_q == '0));
	assign sum      = {1'b0, mem_rdata_s1.count} + {1'b0, amt_ext};
	assign sat_cnt  = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
	assign del      = (op_q == OP_REMOVE) && !(amt_ext < mem_rdata_s1.count);
	assign shift_end = (state_q == ST_SHIFT)
		&& (last || (!rd_vld_s1 && (rd_ptr_q >= used_q)));
	assign rd_en    = ((state_q == ST_SEARCH) || (state_q == ST_SHIFT))
		&& (rd_ptr_q < used_q) && !hit && !miss && !shift_end;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_s1;
		wr_data = mem_rdata_s1;
		if (hit) begin
			case (op_q)
				OP_ADD: begin
					wr_en   = 1'b1;
					wr_data = '{key: key_q, count: sat_cnt};
				end
				OP_REMOVE: begin
					wr_en   = !del;
					wr_data = '{key: key_q, count: mem_rdata_s1.count - amt_ext};
				end
				default: wr_en = 1'b0;
			endcase
		end else if (miss) begin
			wr_en   = (op_q == OP_ADD) && has_room;
			wr_addr = used_q[AW-1:0];
			wr_data = '{key: key_q, count: amt_ext};
		end else if ((state_q == ST_SHIFT) && rd_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1 - AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rdata_s1 <= mem[rd_ptr_q[AW-1:0]];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q  <= operation;
			key_q <= item_key;
			amt_q <= amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			rd_ptr_q     <= '0;
			rd_vld_s1    <= 1'b0;
			rd_addr_s1   <= '0;
			done         <= 1'b0;
			found        <= 1'b0;
			position     <= '0;
			count_after  <= '0;
			entries_used <= '0;
			table_full   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (rd_en) begin
				rd_ptr_q   <= rd_ptr_q + CW'(1);
				rd_vld_s1  <= 1'b1;
				rd_addr_s1 <= rd_ptr_q[AW-1:0];
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_SEARCH;
						rd_ptr_q <= '0;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						found        <= 1'b1;
						position     <= POS_W'(32'(rd_addr_s1));
						table_full   <= 1'b0;
						entries_used <= USED_W'(32'(used_q));
						case (op_q)
							OP_ADD:    count_after <= sat_cnt;
							OP_REMOVE: count_after <= del ? '0
								: mem_rdata_s1.count - amt_ext;
							default:   count_after <= mem_rdata_s1.count;
						endcase
						if (del) begin
							state_q      <= ST_SHIFT;
							rd_ptr_q     <= CW'(rd_addr_s1) + CW'(1);
							entries_used <= USED_W'(32'(used_q - CW'(1)));
						end else begin
							state_q <= ST_IDLE;
							done    <= 1'b1;
						end
					end else if (miss) begin
						state_q      <= ST_IDLE;
						done         <= 1'b1;
						found        <= 1'b0;
						position     <= has_room ? POS_W'(32'(used_q)) : '0;
						entries_used <= USED_W'(32'(used_q));
						count_after  <= '0;
						table_full   <= (op_q == OP_ADD) && !has_room;
						if ((op_q == OP_ADD) && has_room) begin
							used_q       <= used_q + CW'(1);
							entries_used <= USED_W'(32'(used_q + CW'(1)));
							count_after  <= amt_ext;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_end) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
						used_q  <= used_q - CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_full_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> !found && (count_after == '0))
		else $error("full flag on a found key");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) && wr_en |-> (wr_addr < rd_addr_s1))
		else $error("shift write not behind read");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_count_table_top.
// Query, add, remove and spare-opcode transactions are sent in bursts with
// random gaps. A shadow copy of the table predicts every result, and each done
// strobe is checked against the oldest prediction. The run covers an empty, a
// full and a draining table and deletion with shift-down.
// ----------------------------------------------------------------------------
module tb;
	import kct_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_POOL = 96;
	localparam int RANDOM_ITEMS = 1950;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	localparam logic [KEY_W-1:0] KEY_ALT    = 64'hA5A5_5A5A_0F0F_F0F0;
	localparam logic [KEY_W-1:0] KEY_ABSENT = 64'h5555_AAAA_3333_CCCC;

	typedef enum int {MIX_PHASE, FILL_PHASE, DRAIN_PHASE, NOISE_PHASE} phase_t;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  position;
		logic [CNT_W-1:0]  count_after;
		logic [USED_W-1:0] entries_used;
		logic              table_full;
	} outcome_t;

	class count_table_scoreboard;
		logic [KEY_W-1:0] keys [TABLE_DEPTH];
		logic [CNT_W-1:0] counts [TABLE_DEPTH];
		int used;
		outcome_t expected_outcomes[$];
		int errors, shown;
		int commands, hits, deletions, dropped, saturated, peak_used;

		function string describe(outcome_t o);
			return $sformatf("found=%0b pos=%0d count=%08h used=%0d full=%0b",
				o.found, o.position, o.count_after, o.entries_used, o.table_full);
		endfunction

		function void flag(string what);
			errors++;
			if (shown < 10) begin
				shown++;
				$display("MISMATCH %s", what);
			end
		endfunction

		function void note_command(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
				logic [AMT_W-1:0] amt);
			outcome_t r;
			logic [CNT_W:0] sum;
			logic [CNT_W-1:0] c;
			int idx;
			bit hit;
			r = '0;
			idx = 0;
			hit = 1'b0;
			commands++;
			for (int k = 0; k < used; k++)
				if (!hit && keys[k] == key) begin
					idx = k;
					hit = 1'b1;
				end
			r.found = hit;
			if (!hit) begin
				// no free index on a full table: position reads 0
				r.position = (used < TABLE_DEPTH) ? POS_W'(used) : '0;
				if (op == OP_ADD) begin
					if (used < TABLE_DEPTH) begin
						keys[used] = key;
						counts[used] = CNT_W'(amt);
						used++;
						r.count_after = CNT_W'(amt);
					end else begin
						r.table_full = 1'b1;
						dropped++;
					end
				end
			end else begin
				hits++;
				r.position = POS_W'(idx);
				c = counts[idx];
				if (op == OP_ADD) begin
					sum = {1'b0, c} + (CNT_W + 1)'(amt);
					if (sum[CNT_W]) begin
						c = COUNT_MAX;
						saturated++;
					end else begin
						c = sum[CNT_W-1:0];
					end
					counts[idx] = c;
				end else if (op == OP_REMOVE) begin
					if (CNT_W'(amt) < c) begin
						c = c - CNT_W'(amt);
						counts[idx] = c;
					end else begin
						for (int k = idx; k + 1 < used; k++) begin
							keys[k] = keys[k + 1];
							counts[k] = counts[k + 1];
						end
						used--;
						c = '0;
						deletions++;
					end
				end
				r.count_after = c;
			end
			r.entries_used = USED_W'(used);
			if (used > peak_used)
				peak_used = used;
			expected_outcomes.push_back(r);
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (expected_outcomes.size() == 0) begin
				flag({"unexpected result: ", describe(got)});
				return;
			end
			want = expected_outcomes.pop_front();
			if (got.found !== want.found || got.position !== want.position ||
					got.count_after !== want.count_after ||
					got.entries_used !== want.entries_used ||
					got.table_full !== want.table_full)
				flag({"expected ", describe(want), " got ", describe(got)});
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [OP_W-1:0]   operation;
	logic [KEY_W-1:0]  item_key;
	logic [AMT_W-1:0]  amount;
	logic              done;
	logic              found;
	logic [POS_W-1:0]  position;
	logic [CNT_W-1:0]  count_after;
	logic [USED_W-1:0] entries_used;
	logic              table_full;

	count_table_scoreboard board;
	longint cycle_count = 0;

	logic [KEY_W-1:0] key_pool [KEY_POOL];
	logic [OP_W-1:0]  op;
	logic [KEY_W-1:0] key;
	logic [AMT_W-1:0] amt;
	phase_t phase;
	int sent, episode, run_len, span, base, roll, burst_left;

	keyed_count_table_top #(
		.CAPACITY(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.item_key(item_key),
		.amount(amount),
		.done(done),
		.found(found),
		.position(position),
		.count_after(count_after),
		.entries_used(entries_used),
		.table_full(table_full)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// results first: a done and a new transaction may share an edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				board.check_result({found, position, count_after, entries_used, table_full});
			if (start && busy === 1'b0)
				board.note_command(operation, item_key, amount);
		end
	end

	task automatic send_command(logic [OP_W-1:0] c_op, logic [KEY_W-1:0] c_key,
			logic [AMT_W-1:0] c_amt);
		start <= 1'b1;
		operation <= c_op;
		item_key <= c_key;
		amount <= c_amt;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic await_quiet();
		start <= 1'b0;
		do @(posedge clk); while (board.expected_outcomes.size() != 0);
	endtask

	initial begin
		board = new;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_QUERY;
		item_key = '0;
		amount = '0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, $urandom};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, spare opcode, delete and shift
		send_command(OP_QUERY, '0, '0);
		send_command(OP_REMOVE, '1, 16'd5);
		send_command(OP_ADD, '0, '0);
		send_command(OP_ADD, '1, '1);
		send_command(OP_SPARE, '1, 16'h1234);
		send_command(OP_SPARE, KEY_ABSENT, '0);
		send_command(OP_REMOVE, '0, '0);
		send_command(OP_ADD, '0, 16'd3);
		send_command(OP_ADD, KEY_ALT, 16'd7);
		send_command(OP_ADD, '1, 16'd1);
		send_command(OP_REMOVE, '1, '1);
		send_command(OP_REMOVE, '0, 16'd3);
		send_command(OP_QUERY, KEY_ALT, '1);
		send_command(OP_REMOVE, KEY_ALT, '1);
		send_command(OP_QUERY, '0, '0);
		send_command(OP_ADD, '0, 16'h8000);
		send_command(OP_ADD, KEY_ABSENT, 16'h7FFF);
		send_command(OP_REMOVE, '1, 16'd1);
		send_command(OP_REMOVE, KEY_ABSENT, 16'h7FFF);
		send_command(OP_REMOVE, '0, '1);
		await_quiet();

		sent = 0;
		episode = 0;
		burst_left = 0;
		while (sent < RANDOM_ITEMS) begin
			case (episode % 4)
				0: phase = FILL_PHASE;
				1: phase = MIX_PHASE;
				2: phase = DRAIN_PHASE;
				default: phase = NOISE_PHASE;
			endcase
			span = (phase == MIX_PHASE) ? $urandom_range(2, 20) : 72;
			base = $urandom_range(0, KEY_POOL - span);
			run_len = (phase == FILL_PHASE) ? 220 : $urandom_range(60, 180);
			if (episode % 3 == 2)
				await_quiet();
			for (int n = 0; n < run_len && sent < RANDOM_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				case (phase)
					FILL_PHASE:  op = (roll < 80) ? OP_ADD : (roll < 90) ? OP_QUERY : OP_REMOVE;
					DRAIN_PHASE: op = (roll < 70) ? OP_REMOVE : (roll < 85) ? OP_QUERY : OP_ADD;
					MIX_PHASE:   op = (roll < 40) ? OP_ADD : (roll < 75) ? OP_REMOVE :
							(roll < 95) ? OP_QUERY : OP_SPARE;
					default:     op = OP_W'($urandom_range(0, 3));
				endcase
				key = key_pool[base + $urandom_range(0, span - 1)];
				if (phase == NOISE_PHASE && $urandom_range(0, 1))
					key = {$urandom, $urandom};
				roll = $urandom_range(0, 99);
				if (roll < 10)
					amt = '0;
				else if (roll < 40)
					amt = AMT_W'($urandom_range(1, 8));
				else if (roll < 90)
					amt = AMT_W'($urandom);
				else
					amt = '1;
				if (phase == DRAIN_PHASE && op == OP_REMOVE && $urandom_range(0, 1))
					amt = '1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if ($urandom_range(0, 3) != 0)
						pause_sender($urandom_range(1, 12));
				end
				burst_left--;
				send_command(op, key, amt);
				sent++;
			end
			episode++;
		end

		await_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.expected_outcomes.size() != 0)
			board.flag($sformatf("%0d results never arrived", board.expected_outcomes.size()));

		$display("covered %0d transactions: %0d hits, %0d deletions, %0d adds dropped when full",
			board.commands, board.hits, board.deletions, board.dropped);
		$display("%0d clipped adds, peak occupancy %0d of %0d, %0d mismatches",
			board.saturated, board.peak_used, TABLE_DEPTH, board.errors);
		if (board.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

### keyed_count_table_top.f
rtl/kct_pkg.sv
rtl/keyed_count_table_top.sv
dv/tb.sv
